// ===== src/usv_pkg.sv =====
`default_nettype none

package usv_pkg;

    localparam int USV_COUNT_BITS = 16;
    localparam int CP_BITS        = 21;
    localparam int CLS_NUM        = 6;
    localparam int PERMILLE_BITS  = 10;
    localparam int PERMILLE_SCALE = 1000;

    typedef enum logic [2:0] {
        CLS_UNKNOWN = 3'd0,
        CLS_ZH      = 3'd1,
        CLS_EN      = 3'd2,
        CLS_JA      = 3'd3,
        CLS_KO      = 3'd4,
        CLS_OTHER   = 3'd5
    } cls_t;

    // up to two code points finish on one byte
    typedef struct packed {
        logic valid0;
        cls_t cls0;
        logic wide0;
        logic valid1;
        cls_t cls1;
        logic wide1;
    } usv_tally_t;

    function automatic cls_t classify(input logic [CP_BITS-1:0] cp);
        cls_t c;
        c = CLS_UNKNOWN;
        if ((cp >= 21'h4E00 && cp <= 21'h9FFF) || (cp >= 21'h3400 && cp <= 21'h4DBF))
            c = CLS_ZH;
        else if ((cp >= 21'h3040 && cp <= 21'h30FF) || (cp >= 21'hFF66 && cp <= 21'hFF9D))
            c = CLS_JA;
        else if ((cp >= 21'hAC00 && cp <= 21'hD7AF) || (cp >= 21'h1100 && cp <= 21'h11FF))
            c = CLS_KO;
        else if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A)
                 || (cp >= 21'hC0 && cp <= 21'h24F))
            c = CLS_EN;
        else if ((cp >= 21'h370 && cp <= 21'h4FF) || (cp >= 21'h590 && cp <= 21'h6FF)
                 || (cp >= 21'h900 && cp <= 21'h97F)
                 || (cp >= 21'h1F300 && cp <= 21'h1FAFF))
            c = CLS_OTHER;
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/usv_decode.sv =====
`default_nettype none

module usv_decode
    import usv_pkg::*;
(
    input  wire logic [7:0]         text_byte,
    input  wire logic               end_of_text,
    input  wire logic [CP_BITS-1:0] partial,
    input  wire logic [1:0]         pending,
    output usv_tally_t              tally,
    output logic [CP_BITS-1:0]      partial_next,
    output logic [1:0]              pending_next
);

    logic [CP_BITS-1:0] cp0;
    logic [CP_BITS-1:0] cp1;
    logic               has0;
    logic               has1;
    logic               do_start;
    logic [CP_BITS-1:0] shifted;

    assign shifted = {partial[CP_BITS-7:0], text_byte[5:0]};

    always_comb
    begin
        cp0          = '0;
        cp1          = '0;
        has0         = 1'b0;
        has1         = 1'b0;
        do_start     = 1'b0;
        partial_next = '0;
        pending_next = 2'd0;

        if (pending != 2'd0 && text_byte[7:6] == 2'b10)
        begin
            pending_next = pending - 2'd1;
            partial_next = shifted;
            if (pending_next == 2'd0)
            begin
                cp0          = shifted;
                has0         = 1'b1;
                partial_next = '0;
            end
        end
        else
        begin
            if (pending != 2'd0)
            begin
                cp0  = partial;
                has0 = 1'b1;
            end
            do_start = 1'b1;
        end

        if (do_start)
        begin
            if (text_byte[7] == 1'b0)
            begin
                cp1  = {{(CP_BITS-8){1'b0}}, text_byte};
                has1 = 1'b1;
            end
            else if (text_byte[7:5] == 3'b110)
            begin
                partial_next = {{(CP_BITS-5){1'b0}}, text_byte[4:0]};
                pending_next = 2'd1;
            end
            else if (text_byte[7:4] == 4'b1110)
            begin
                partial_next = {{(CP_BITS-4){1'b0}}, text_byte[3:0]};
                pending_next = 2'd2;
            end
            else if (text_byte[7:3] == 5'b11110)
            begin
                partial_next = {{(CP_BITS-3){1'b0}}, text_byte[2:0]};
                pending_next = 2'd3;
            end
        end

        // unfinished sequence at end of text
        if (end_of_text)
        begin
            if (pending_next != 2'd0)
            begin
                cp1  = partial_next;
                has1 = 1'b1;
            end
            partial_next = '0;
            pending_next = 2'd0;
        end
    end

    always_comb
    begin
        tally.valid0 = has0 && (cp0 != '0);
        tally.cls0   = classify(cp0);
        tally.wide0  = (cp0 > 21'h7F);
        tally.valid1 = has1 && (cp1 != '0);
        tally.cls1   = classify(cp1);
        tally.wide1  = (cp1 > 21'h7F);
    end

endmodule

`default_nettype wire

// ===== src/usv_div.sv =====
`default_nettype none

module usv_div
    import usv_pkg::*;
#(
    parameter int DW = USV_COUNT_BITS + PERMILLE_BITS,
    parameter int VW = USV_COUNT_BITS
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dvs_reg;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[VW-1:0] : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== src/utf8_script_vote.sv =====
`default_nettype none

// UTF-8 script vote. Bytes of text enter one per handshake on text_*; the byte
// flagged end_of_text closes the text and then one item leaves on vote_*: the
// winning script, the zh share of non-ASCII code points in permille and a flag
// for any zh seen. All counts then restart for the next text. Every byte is
// first accepted and decoded, then goes through two slots in which the single
// saturating count incrementer adds the code points that the byte finished. The
// end of text adds a winner search through one shared comparator, bit-serial
// division for the permille (skipped when no non-ASCII code point was seen) and
// a step to load the result. text_stall is low only while the sequencer is
// idle; a finished result waits in the output register while the next text
// streams in. Counters stop at 2^COUNT_BITS - 1.
module utf8_script_vote
    import usv_pkg::*;
#(
    parameter int COUNT_BITS = USV_COUNT_BITS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       text_valid,
    output logic            text_stall,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_text,
    output logic            vote_valid,
    input  wire logic       vote_stall,
    output logic [2:0]      script,
    output logic [9:0]      zh_permille,
    output logic            any_zh
);

    localparam int DW = COUNT_BITS + PERMILLE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TALLY0,
        ST_TALLY1,
        ST_ARGMAX,
        ST_DIVIDE,
        ST_RESULT
    } state_t;

    state_t                 state_reg;
    logic [CP_BITS-1:0]     partial_reg;
    logic [1:0]             pending_reg;
    usv_tally_t             tally_reg;
    logic                   last_reg;
    logic [COUNT_BITS-1:0]  counts_reg [CLS_NUM];
    logic [COUNT_BITS-1:0]  wide_reg;
    cls_t                   arg_idx_reg;
    cls_t                   best_cls_reg;
    logic [COUNT_BITS-1:0]  best_cnt_reg;
    logic [PERMILLE_BITS-1:0] permille_reg;
    logic                   vote_valid_reg;
    logic [2:0]             script_reg;
    logic [PERMILLE_BITS-1:0] zh_permille_reg;
    logic                   any_zh_reg;

    usv_tally_t             tally_next;
    logic [CP_BITS-1:0]     partial_next;
    logic [1:0]             pending_next;
    logic                   accept;
    logic                   slot_valid;
    cls_t                   slot_cls;
    logic                   slot_wide;
    cls_t                   rd_idx;
    logic [COUNT_BITS-1:0]  rd_cnt;
    logic [COUNT_BITS-1:0]  inc_cnt;
    logic                   take;
    logic                   div_start;
    logic                   div_done;
    logic [DW-1:0]          quotient;
    logic [DW-1:0]          dividend;
    logic                   out_free;

    usv_decode u_decode (
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .partial      (partial_reg),
        .pending      (pending_reg),
        .tally        (tally_next),
        .partial_next (partial_next),
        .pending_next (pending_next)
    );

    assign accept     = text_valid && (state_reg == ST_IDLE);
    assign text_stall = (state_reg != ST_IDLE);
    assign out_free   = !vote_valid_reg || !vote_stall;

    always_comb
    begin
        slot_valid = 1'b0;
        slot_cls   = tally_reg.cls0;
        slot_wide  = tally_reg.wide0;
        if (state_reg == ST_TALLY0)
        begin
            slot_valid = tally_reg.valid0;
        end
        else if (state_reg == ST_TALLY1)
        begin
            slot_valid = tally_reg.valid1;
            slot_cls   = tally_reg.cls1;
            slot_wide  = tally_reg.wide1;
        end
    end

    // one read port serves both the incrementer and the winner search
    assign rd_idx  = (state_reg == ST_ARGMAX) ? arg_idx_reg : slot_cls;
    assign rd_cnt  = counts_reg[rd_idx];
    assign inc_cnt = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
    assign take    = (arg_idx_reg == CLS_UNKNOWN) || (rd_cnt > best_cnt_reg);

    assign dividend  = DW'(counts_reg[CLS_ZH]) * DW'(PERMILLE_SCALE);
    assign div_start = (state_reg == ST_ARGMAX) && (arg_idx_reg == CLS_OTHER)
                       && (wide_reg != '0);

    usv_div #(
        .DW (DW),
        .VW (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (wide_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            partial_reg    <= '0;
            pending_reg    <= 2'd0;
            last_reg       <= 1'b0;
            tally_reg      <= '0;
            for (int i = 0; i < CLS_NUM; i++)
            begin
                counts_reg[i] <= '0;
            end
            wide_reg       <= '0;
            arg_idx_reg    <= CLS_UNKNOWN;
            best_cls_reg   <= CLS_UNKNOWN;
            best_cnt_reg   <= '0;
            permille_reg   <= '0;
            vote_valid_reg <= 1'b0;
            script_reg     <= '0;
            zh_permille_reg <= '0;
            any_zh_reg     <= 1'b0;
        end
        else
        begin
            if (vote_valid_reg && !vote_stall && state_reg != ST_RESULT)
            begin
                vote_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        partial_reg <= partial_next;
                        pending_reg <= pending_next;
                        tally_reg   <= tally_next;
                        last_reg    <= end_of_text;
                        state_reg   <= ST_TALLY0;
                    end
                end
                ST_TALLY0, ST_TALLY1:
                begin
                    if (slot_valid)
                    begin
                        counts_reg[slot_cls] <= inc_cnt;
                        if (slot_wide && wide_reg != '1)
                        begin
                            wide_reg <= wide_reg + COUNT_BITS'(1);
                        end
                    end
                    if (state_reg == ST_TALLY0)
                    begin
                        state_reg <= ST_TALLY1;
                    end
                    else if (last_reg)
                    begin
                        arg_idx_reg <= CLS_UNKNOWN;
                        state_reg   <= ST_ARGMAX;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ARGMAX:
                begin
                    if (take)
                    begin
                        best_cls_reg <= arg_idx_reg;
                        best_cnt_reg <= rd_cnt;
                    end
                    if (arg_idx_reg == CLS_OTHER)
                    begin
                        permille_reg <= '0;
                        state_reg    <= (wide_reg != '0) ? ST_DIVIDE : ST_RESULT;
                    end
                    else
                    begin
                        arg_idx_reg <= cls_t'(arg_idx_reg + 3'd1);
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                    begin
                        if (quotient > DW'(PERMILLE_SCALE))
                            permille_reg <= PERMILLE_BITS'(PERMILLE_SCALE);
                        else
                            permille_reg <= quotient[PERMILLE_BITS-1:0];
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT:
                begin
                    if (out_free)
                    begin
                        vote_valid_reg  <= 1'b1;
                        script_reg      <= best_cls_reg;
                        zh_permille_reg <= permille_reg;
                        any_zh_reg      <= (counts_reg[CLS_ZH] != '0);
                        for (int i = 0; i < CLS_NUM; i++)
                        begin
                            counts_reg[i] <= '0;
                        end
                        wide_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign vote_valid  = vote_valid_reg;
    assign script      = script_reg;
    assign zh_permille = zh_permille_reg;
    assign any_zh      = any_zh_reg;

`ifndef SYNTHESIS
    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside divide state");

    a_permille_range: assert property (@(posedge clk) disable iff (!rst_n)
        vote_valid |-> zh_permille <= 10'd1000)
        else $error("permille above 1000");

    a_no_zh_no_share: assert property (@(posedge clk) disable iff (!rst_n)
        (vote_valid && !any_zh) |-> zh_permille == 10'd0)
        else $error("zh share without zh code points");

    a_partial_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd0 |-> partial_reg == '0)
        else $error("partial code point left without pending bytes");
`endif

endmodule

`default_nettype wire
